FILE: rtl/cdss_pkg.sv
`timescale 1ns / 1ps

package cdss_pkg;

	// payload widths
	localparam int CYL_W   = 12;
	localparam int LAST_W  = 13;
	localparam int COUNT_W = 13;
	localparam int MOVE_W  = 19;

	localparam logic [MOVE_W-1:0] MOVE_MAX = '1;

	// apb register file
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_SCAN_MODE      = 2'd0;
	localparam reg_idx_t REG_CYLINDER_COUNT = 2'd1;
	localparam reg_idx_t REG_START_POSITION = 2'd2;

	localparam logic               SCAN_MODE_RST = 1'b0;
	localparam logic [COUNT_W-1:0] CYL_COUNT_RST = 13'd500;
	localparam logic [CYL_W-1:0]   START_POS_RST = 12'd85;

	// scan modes
	localparam logic MODE_CSCAN = 1'b0;
	localparam logic MODE_CLOOK = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_FIND_RD,
		ST_FIND_CMP,
		ST_EMIT_RD,
		ST_EMIT_CALC,
		ST_WRAP
	} state_t;

endpackage

FILE: rtl/cdss_req_if.sv
`timescale 1ns / 1ps

interface cdss_req_if
	import cdss_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CYL_W-1:0] request_cylinder;
	logic             last_request;

	modport source (output valid, request_cylinder, last_request, input ready);
	modport sink (input valid, request_cylinder, last_request, output ready);
endinterface

FILE: rtl/cdss_res_if.sv
`timescale 1ns / 1ps

interface cdss_res_if
	import cdss_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CYL_W-1:0]  served_cylinder;
	logic [MOVE_W-1:0] movement_total;
	logic              end_of_order;
	logic              requests_dropped;

	modport source (output valid, served_cylinder, movement_total, end_of_order,
		requests_dropped, input ready);
	modport sink (input valid, served_cylinder, movement_total, end_of_order,
		requests_dropped, output ready);
endinterface

FILE: rtl/circular_disk_seek_scheduler_core.sv
`timescale 1ns / 1ps

// Circular (C-SCAN / C-LOOK) disk seek scheduler.
// Request words arrive on req: one cylinder each, the last word of a batch
// marked by last_request. Each word is saturated to the last cylinder and
// placed in sorted order in a request memory by an insertion sequencer that
// compares and shifts one entry at a time (a read state, then a compare
// state), so a word holds req off until it is in place.
// A word arriving once the memory is full is dropped and flags the batch.
// After the marked word the sequencer scans for the first entry at or above
// the start position, reading and comparing each entry below it, then emits
// result words on res, each read and then calculated: upper requests
// ascending, then lower ones, each with the running head-movement total from
// a shared difference and saturating add unit, with a wrap state between.
// req.ready is high only while the sequencer is idle. A single output
// register holds each result; while res stalls the sequencer waits on it,
// and a new batch is taken while the final result still waits.
// Write registers over the APB port only while idle; the block does not check.
// Reset (arst_n low) empties the batch and restores register defaults;
// the request memory needs no clearing.
module circular_disk_seek_scheduler_core
	import cdss_pkg::*;
#(
	parameter int MAX_REQUESTS  = 64,
	parameter int MAX_CYLINDERS = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	cdss_req_if.sink          req,
	cdss_res_if.source        res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);
	localparam logic [16:0]      CYL_MAX = 17'(MAX_CYLINDERS);

	// configuration registers
	logic               scan_mode_q;
	logic [COUNT_W-1:0] cyl_count_q;
	logic [CYL_W-1:0]   start_pos_q;

	// sequencer and datapath registers
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  f_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  i_q;
	logic [CYL_W-1:0]  val_q;
	logic              mark_q;
	logic              over_q;
	logic              upper_q;
	logic              skip_q;
	logic [LAST_W-1:0] head_q;
	logic [MOVE_W-1:0] sum_q;

	// request memory
	logic [CYL_W-1:0] mem_q [MAX_REQUESTS];
	logic [CYL_W-1:0] rd_data_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [CYL_W-1:0] mem_wd;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;

	// output register
	logic              out_valid_q;
	logic [CYL_W-1:0]  out_cyl_q;
	logic [MOVE_W-1:0] out_total_q;
	logic              out_end_q;
	logic              out_drop_q;

	// control strobes
	logic prep;
	logic out_load;
	logic finish;
	logic out_free;

	// derived values
	logic [16:0]       cnt_ext;
	logic [16:0]       cnt_clamp;
	logic [LAST_W-1:0] last_cyl;
	logic [CYL_W-1:0]  in_sat;
	logic [CYL_W-1:0]  start_sat;
	logic              cfg_wr;
	logic              in_acc;
	logic              ins_gt;
	logic              found;
	logic              i_last_n;
	logic              i_last_f;
	logic              end_flag;

	// shared movement unit
	logic [LAST_W-1:0] mv_tgt;
	logic [LAST_W-1:0] mv_diff;
	logic [MOVE_W:0]   mv_wide;
	logic [MOVE_W-1:0] mv_sum;

	// last cylinder from the clamped count
	always_comb begin
		cnt_ext = 17'(cyl_count_q);
		if (cnt_ext < 17'd2) begin
			cnt_clamp = 17'd2;
		end else if (cnt_ext > CYL_MAX) begin
			cnt_clamp = CYL_MAX;
		end else begin
			cnt_clamp = cnt_ext;
		end
		last_cyl = LAST_W'(cnt_clamp - 17'd1);
	end

	// saturation of request and start cylinders
	assign in_sat    = ({1'b0, req.request_cylinder} > last_cyl) ? CYL_W'(last_cyl)
		: req.request_cylinder;
	assign start_sat = ({1'b0, start_pos_q} > last_cyl) ? CYL_W'(last_cyl) : start_pos_q;

	// apb register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			REG_SCAN_MODE:      prdata = APB_DW'(scan_mode_q);
			REG_CYLINDER_COUNT: prdata = APB_DW'(cyl_count_q);
			REG_START_POSITION: prdata = APB_DW'(start_pos_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode_q <= SCAN_MODE_RST;
			cyl_count_q <= CYL_COUNT_RST;
			start_pos_q <= START_POS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SCAN_MODE:      scan_mode_q <= pwdata[0];
				REG_CYLINDER_COUNT: cyl_count_q <= pwdata[COUNT_W-1:0];
				REG_START_POSITION: start_pos_q <= pwdata[CYL_W-1:0];
				default: ;
			endcase
		end
	end

	// handshakes
	assign req.ready = (state_q == ST_IDLE);
	assign in_acc    = req.valid && req.ready;
	assign out_free  = !out_valid_q || res.ready;

	// compare results
	assign ins_gt   = rd_data_q > val_q;
	assign found    = rd_data_q >= start_sat;
	assign i_last_n = (CNT_W'(i_q) + CNT_W'(1)) == count_q;
	assign i_last_f = (CNT_W'(i_q) + CNT_W'(1)) == f_q;
	assign end_flag = upper_q ? ((f_q == '0) && i_last_n) : i_last_f;

	// difference and saturating add, shared by emission and wrap sweep
	always_comb begin
		mv_tgt = (state_q == ST_WRAP) ? last_cyl : {1'b0, rd_data_q};
		if (skip_q && (state_q != ST_WRAP)) begin
			mv_diff = '0;
		end else if (head_q > mv_tgt) begin
			mv_diff = head_q - mv_tgt;
		end else begin
			mv_diff = mv_tgt - head_q;
		end
		mv_wide = {1'b0, sum_q} + (MOVE_W + 1)'(mv_diff);
		mv_sum  = mv_wide[MOVE_W] ? MOVE_MAX : mv_wide[MOVE_W-1:0];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d  = state_q;
		mem_we   = 1'b0;
		mem_wa   = j_q;
		mem_wd   = val_q;
		rd_en    = 1'b0;
		rd_addr  = i_q;
		prep     = 1'b0;
		out_load = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (count_q < CNT_MAX) begin
						state_d = ST_INS_RD;
					end else if (req.last_request) begin
						state_d = ST_FIND_RD;
						prep    = 1'b1;
					end
				end
			end
			ST_INS_RD: begin
				if (j_q == '0) begin
					mem_we = 1'b1;
					if (mark_q) begin
						state_d = ST_FIND_RD;
						prep    = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = j_q - IDX_W'(1);
					state_d = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				mem_we = 1'b1;
				if (ins_gt) begin
					mem_wd  = rd_data_q;
					state_d = ST_INS_RD;
				end else if (mark_q) begin
					state_d = ST_FIND_RD;
					prep    = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FIND_RD: begin
				rd_en   = 1'b1;
				state_d = ST_FIND_CMP;
			end
			ST_FIND_CMP: begin
				if (found) begin
					state_d = ST_EMIT_CALC;
				end else if (i_last_n) begin
					state_d = ST_WRAP;
				end else begin
					state_d = ST_FIND_RD;
				end
			end
			ST_EMIT_RD: begin
				rd_en   = 1'b1;
				state_d = ST_EMIT_CALC;
			end
			ST_EMIT_CALC: begin
				if (out_free) begin
					out_load = 1'b1;
					if (upper_q && i_last_n) begin
						if (f_q == '0) begin
							finish  = 1'b1;
							state_d = ST_IDLE;
						end else begin
							state_d = ST_WRAP;
						end
					end else if (!upper_q && i_last_f) begin
						finish  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_EMIT_RD;
					end
				end
			end
			ST_WRAP: begin
				state_d = ST_EMIT_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// batch control and head tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			over_q  <= 1'b0;
			mark_q  <= 1'b0;
			upper_q <= 1'b1;
			skip_q  <= 1'b0;
			f_q     <= '0;
			j_q     <= '0;
			i_q     <= '0;
			head_q  <= '0;
			sum_q   <= '0;
		end else begin
			if (in_acc) begin
				mark_q <= req.last_request;
				if (count_q < CNT_MAX) begin
					j_q     <= IDX_W'(count_q);
					count_q <= count_q + CNT_W'(1);
				end else begin
					over_q <= 1'b1;
				end
			end
			if ((state_q == ST_INS_CMP) && ins_gt) begin
				j_q <= j_q - IDX_W'(1);
			end
			if (prep) begin
				i_q     <= '0;
				upper_q <= 1'b1;
				skip_q  <= 1'b0;
				head_q  <= {1'b0, start_sat};
				sum_q   <= '0;
			end
			if (state_q == ST_FIND_CMP) begin
				if (found) begin
					f_q <= CNT_W'(i_q);
				end else if (i_last_n) begin
					f_q <= count_q;
				end else begin
					i_q <= i_q + IDX_W'(1);
				end
			end
			if (state_q == ST_WRAP) begin
				upper_q <= 1'b0;
				i_q     <= '0;
				if (scan_mode_q == MODE_CSCAN) begin
					sum_q  <= mv_sum;
					head_q <= '0;
				end else begin
					skip_q <= 1'b1;
				end
			end
			if (out_load) begin
				head_q <= {1'b0, rd_data_q};
				sum_q  <= mv_sum;
				skip_q <= 1'b0;
				i_q    <= i_q + IDX_W'(1);
			end
			if (finish) begin
				count_q <= '0;
				over_q  <= 1'b0;
			end
		end
	end

	// payload registers with no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			val_q <= in_sat;
		end
	end

	// request memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_cyl_q   <= rd_data_q;
			out_total_q <= mv_sum;
			out_end_q   <= end_flag;
			out_drop_q  <= over_q;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.served_cylinder  = out_cyl_q;
	assign res.movement_total   = out_total_q;
	assign res.end_of_order     = out_end_q;
	assign res.requests_dropped = out_drop_q;

endmodule

FILE: rtl/cdss_checker.sv
`timescale 1ns / 1ps

module cdss_checker
	import cdss_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_last,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CYL_W-1:0]  out_cyl,
	input logic [MOVE_W-1:0] out_total,
	input logic              out_end,
	input logic              out_drop
);

	logic              mid_q;
	logic [MOVE_W-1:0] prev_total_q;
	logic              prev_drop_q;

	// track the previous word of the current batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q        <= 1'b0;
			prev_total_q <= '0;
			prev_drop_q  <= 1'b0;
		end else if (out_valid && out_ready) begin
			mid_q        <= !out_end;
			prev_total_q <= out_total;
			prev_drop_q  <= out_drop;
		end
	end

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_cyl)
			&& $stable(out_total) && $stable(out_end) && $stable(out_drop))
		else $error("result word changed while stalled");

	// a marked request starts insertion or the scan, so input is closed next cycle
	a_mark_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input ready right after a marked request");

	// movement total never falls within one batch
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mid_q |-> out_total >= prev_total_q)
		else $error("movement total decreased within a batch");

	// drop flag is the same on every word of a batch
	a_drop_const: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mid_q |-> out_drop == prev_drop_q)
		else $error("requests_dropped changed within a batch");

endmodule

bind circular_disk_seek_scheduler_core cdss_checker u_cdss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.in_last   (req.last_request),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_cyl   (res.served_cylinder),
	.out_total (res.movement_total),
	.out_end   (res.end_of_order),
	.out_drop  (res.requests_dropped)
);

FILE: bench/circular_disk_seek_scheduler_core_tb.sv
`timescale 1ns / 1ps

module circular_disk_seek_scheduler_core_tb;
	import cdss_pkg::*;

	localparam int MAX_REQUESTS  = 64;
	localparam int MAX_CYLINDERS = 4096;
	localparam int RANDOM_WORDS  = 350;

	typedef struct packed {
		logic [CYL_W-1:0] cyl;
		logic             mark;
	} request_word_t;

	typedef struct packed {
		logic [CYL_W-1:0]  served_cylinder;
		logic [MOVE_W-1:0] movement_total;
		logic              end_of_order;
		logic              requests_dropped;
	} service_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	cdss_req_if req ();
	cdss_res_if res ();

	circular_disk_seek_scheduler_core #(
		.MAX_REQUESTS (MAX_REQUESTS),
		.MAX_CYLINDERS(MAX_CYLINDERS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.res    (res.source),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// shadow of the register file
	logic cfg_mode  = SCAN_MODE_RST;
	int   cfg_count = int'(CYL_COUNT_RST);
	int   cfg_start = int'(START_POS_RST);

	// scheduler shadow state and expected service order
	int            held_cyl[$];
	logic          batch_dropped = 1'b0;
	service_t      expected_services[$];
	request_word_t pending_words[$];

	int words_queued   = 0;
	int words_accepted = 0;
	int fail_count     = 0;
	int random_total   = 0;

	// idling control
	logic idle_on   = 1'b1;
	logic hold_arm  = 1'b0;
	logic hold_done = 1'b0;
	int   gap_left       = 0;
	int   stall_left     = 0;
	int   long_hold_left = 0;
	logic          next_valid;
	logic          next_ready;
	request_word_t word;
	service_t      want;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("simulation failed");
		$finish;
	end

	// head movement with saturation
	function automatic int seek(int total, int from_cyl, int to_cyl);
		int d;
		d = (from_cyl > to_cyl) ? from_cyl - to_cyl : to_cyl - from_cyl;
		total = total + d;
		if (total > int'(MOVE_MAX))
			total = int'(MOVE_MAX);
		return total;
	endfunction

	function automatic void push_service(int cyl, int total, logic last_one);
		service_t svc;
		svc.served_cylinder  = CYL_W'(cyl);
		svc.movement_total   = MOVE_W'(total);
		svc.end_of_order     = last_one;
		svc.requests_dropped = batch_dropped;
		expected_services.push_back(svc);
	endfunction

	// store one request and, on the marked one, work out the service order
	function automatic void stage_request(logic [CYL_W-1:0] cyl_in, logic mark);
		int last_cyl;
		int cyl;
		int start;
		int head;
		int total;
		int lower_n;
		int n;
		int i;
		last_cyl = cfg_count;
		if (last_cyl < 2)
			last_cyl = 2;
		if (last_cyl > MAX_CYLINDERS)
			last_cyl = MAX_CYLINDERS;
		last_cyl = last_cyl - 1;
		cyl = (int'(cyl_in) > last_cyl) ? last_cyl : int'(cyl_in);
		if (held_cyl.size() < MAX_REQUESTS)
			held_cyl.push_back(cyl);
		else
			batch_dropped = 1'b1;
		if (!mark)
			return;
		held_cyl.sort();
		n = held_cyl.size();
		start = (cfg_start > last_cyl) ? last_cyl : cfg_start;
		head = start;
		total = 0;
		lower_n = 0;
		while (lower_n < n && held_cyl[lower_n] < start)
			lower_n++;
		// upward pass from the start position
		for (i = lower_n; i < n; i++) begin
			total = seek(total, head, held_cyl[i]);
			head = held_cyl[i];
			push_service(held_cyl[i], total, (lower_n == 0) && (i == n - 1));
		end
		// wrap to the lower requests
		if (lower_n > 0) begin
			if (cfg_mode == MODE_CSCAN) begin
				total = seek(total, head, last_cyl);
				head = 0;
			end else begin
				head = held_cyl[0];
			end
			for (i = 0; i < lower_n; i++) begin
				total = seek(total, head, held_cyl[i]);
				head = held_cyl[i];
				push_service(held_cyl[i], total, i == lower_n - 1);
			end
		end
		held_cyl.delete();
		batch_dropped = 1'b0;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.request_cylinder <= '0;
			req.last_request <= 1'b0;
			gap_left = 0;
		end else begin
			if (req.valid && req.ready) begin
				stage_request(req.request_cylinder, req.last_request);
				words_accepted++;
			end
			if (!req.valid || req.ready) begin
				next_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_words.size() > 0) begin
					if (idle_on && $urandom_range(0, 7) == 0) begin
						gap_left = $urandom_range(1, 14) - 1;
					end else begin
						word = pending_words.pop_front();
						next_valid = 1'b1;
						req.request_cylinder <= word.cyl;
						req.last_request <= word.mark;
					end
				end
				req.valid <= next_valid;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_left = 0;
			long_hold_left = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_services.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word: cyl %0d move %0d end %0b drop %0b",
							res.served_cylinder, res.movement_total, res.end_of_order,
							res.requests_dropped);
				end else begin
					want = expected_services.pop_front();
					if (res.served_cylinder !== want.served_cylinder ||
						res.movement_total !== want.movement_total ||
						res.end_of_order !== want.end_of_order ||
						res.requests_dropped !== want.requests_dropped) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"result word mismatch: expected cyl %0d move %0d end %0b",
								" drop %0b, got cyl %0d move %0d end %0b drop %0b"},
								want.served_cylinder, want.movement_total,
								want.end_of_order, want.requests_dropped,
								res.served_cylinder, res.movement_total,
								res.end_of_order, res.requests_dropped);
					end
				end
			end
			next_ready = 1'b1;
			// long hold-off starts once a result word is waiting
			if (hold_arm && !hold_done && res.valid) begin
				hold_done = 1'b1;
				long_hold_left = 500;
			end
			if (long_hold_left > 0) begin
				long_hold_left--;
				next_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				next_ready = 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				next_ready = 1'b0;
			end
			res.ready <= next_ready;
		end
	end

	task automatic apb_write(input reg_idx_t idx, input int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SCAN_MODE:      cfg_mode = value[0];
			REG_CYLINDER_COUNT: cfg_count = value & 32'h1FFF;
			REG_START_POSITION: cfg_start = value & 32'hFFF;
			default: ;
		endcase
	endtask

	task automatic write_setting(input logic mode, input int count, input int start);
		apb_write(REG_SCAN_MODE, int'(mode));
		apb_write(REG_CYLINDER_COUNT, count);
		apb_write(REG_START_POSITION, start);
	endtask

	// pick a mix of counts, the extremes included
	task automatic random_setting();
		int count;
		int span;
		int start;
		case ($urandom_range(0, 7))
			0: count = 2;
			1: count = 4096;
			2: count = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) : 8191;
			3: count = 500;
			default: count = $urandom_range(2, 4096);
		endcase
		span = (count < 2) ? 2 : ((count > MAX_CYLINDERS) ? MAX_CYLINDERS : count);
		if ($urandom_range(0, 4) == 0)
			start = $urandom_range(0, 4095);
		else
			start = $urandom_range(0, span - 1);
		write_setting(logic'($urandom_range(0, 1)), count, start);
	endtask

	task automatic queue_word(input int cyl, input logic mark);
		request_word_t w;
		w.cyl = CYL_W'(cyl);
		w.mark = mark;
		pending_words.push_back(w);
		words_queued++;
	endtask

	// one batch of random cylinders, the last word marked
	task automatic queue_batch(input int n);
		int k;
		int cyl;
		int span;
		span = (cfg_count < 2) ? 2 : ((cfg_count > MAX_CYLINDERS) ? MAX_CYLINDERS : cfg_count);
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 3))
				0: cyl = $urandom_range(0, 4095);
				1: cyl = $urandom_range(0, span - 1);
				2: cyl = cfg_start + $urandom_range(0, 6) - 3;
				default: begin
					case ($urandom_range(0, 2))
						0: cyl = 0;
						1: cyl = span - 1;
						default: cyl = 4095;
					endcase
				end
			endcase
			if (cyl < 0)
				cyl = 0;
			if (cyl > 4095)
				cyl = 4095;
			queue_word(cyl, k == n - 1);
			random_total++;
		end
	endtask

	task automatic queue_phase(input int target);
		int phase_words;
		int n;
		phase_words = 0;
		while (phase_words < target) begin
			if ($urandom_range(0, 15) == 0)
				n = $urandom_range(60, 70);
			else
				n = $urandom_range(1, 10);
			queue_batch(n);
			phase_words += n;
		end
	endtask

	task automatic wait_drained();
		while (words_accepted != words_queued || expected_services.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.request_cylinder = '0;
		req.last_request = 1'b0;
		res.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: saturation, equal to start, upper and lower sides
		queue_word(300, 1'b0);
		queue_word(0, 1'b0);
		queue_word(4095, 1'b0);
		queue_word(85, 1'b0);
		queue_word(84, 1'b0);
		queue_word(499, 1'b0);
		queue_word(500, 1'b1);
		// only upper requests, then only lower requests
		queue_word(100, 1'b1);
		queue_word(10, 1'b1);
		wait_drained();

		// c-look wrap
		write_setting(MODE_CLOOK, 500, 85);
		queue_word(200, 1'b0);
		queue_word(5, 1'b0);
		queue_word(90, 1'b0);
		queue_word(3, 1'b1);
		wait_drained();

		// count below minimum, start beyond last cylinder
		apb_write(REG_CYLINDER_COUNT, 0);
		apb_write(REG_START_POSITION, 4095);
		queue_word(0, 1'b0);
		queue_word(1, 1'b0);
		queue_word(4095, 1'b1);
		wait_drained();

		write_setting(MODE_CSCAN, 1, 0);
		queue_word(2, 1'b0);
		queue_word(1, 1'b1);
		wait_drained();

		// count above maximum, full width cylinders
		write_setting(MODE_CSCAN, 8191, 4095);
		queue_word(4095, 1'b0);
		queue_word(0, 1'b0);
		queue_word(2048, 1'b1);
		wait_drained();

		write_setting(MODE_CLOOK, 4096, 2048);
		queue_word(2048, 1'b0);
		queue_word(2047, 1'b1);
		wait_drained();

		// first random phase: overflowing batch under a long receiver hold-off
		random_setting();
		hold_arm = 1'b1;
		queue_batch(65);
		queue_phase(40);
		wait_drained();

		// random phases, some without idling
		while (random_total < RANDOM_WORDS - 40) begin
			idle_on = ($urandom_range(0, 4) != 0);
			random_setting();
			queue_phase($urandom_range(30, 60));
			wait_drained();
		end

		// closing stretch with no idling
		idle_on = 1'b0;
		random_setting();
		queue_phase(40);
		wait_drained();
		repeat (260) @(posedge clk);

		if (fail_count == 0 && expected_services.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
